[rtl/tlb_lru_page_translator_core_defines.svh]
// assertion macros for the translator checker
// expects clk_i and rst_ni in the scope of each use
`ifndef TLB_LRU_PAGE_TRANSLATOR_CORE_DEFINES_SVH
`define TLB_LRU_PAGE_TRANSLATOR_CORE_DEFINES_SVH

`define TLBL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define TLBL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tlbl_pkg.sv]
// shared constants, types and helpers of the tlb page translator
// no dependencies
package tlbl_pkg;

  localparam int unsigned DEF_TLB_ENTRIES = 16;
  localparam int unsigned DEF_PAGE_COUNT  = 256;
  localparam int unsigned DEF_FRAME_COUNT = 256;
  localparam int unsigned DEF_PAGE_BYTES  = 256;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned FRAME_OUT_W = 8;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned AGE_W       = 32;

  typedef enum logic [1:0] {
    ST_TLB_HIT  = 2'd0,
    ST_PT_HIT   = 2'd1,
    ST_FAULT    = 2'd2,
    ST_NO_FRAME = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_LOOK,
    FSM_RESOLVE
  } fsm_e;

  typedef struct packed {
    logic touch;
    logic fill;
  } tlb_op_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

[rtl/tlbl_pt_mem.sv]
// page table memory, one write and one registered read port
// depends on nothing
module tlbl_pt_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 9
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/tlbl_tlb.sv]
// tlb entries with parallel page compare and a registered lru age tree
// depends on tlbl_pkg
module tlbl_tlb #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned PAGE_W  = 8,
  parameter int unsigned FRAME_W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [PAGE_W-1:0]          look_page_i,
  output logic                       hit_o,
  output logic [$clog2(ENTRIES)-1:0] hit_idx_o,
  output logic [FRAME_W-1:0]         hit_frame_o,
  input  tlbl_pkg::tlb_op_t          op_i,
  input  logic [$clog2(ENTRIES)-1:0] op_idx_i,
  input  logic [PAGE_W-1:0]          op_page_i,
  input  logic [FRAME_W-1:0]         op_frame_i,
  input  logic [tlbl_pkg::AGE_W-1:0] op_age_i,
  output logic [$clog2(ENTRIES)-1:0] victim_o,
  output logic                       settled_o
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned LVLS   = IDX_W;
  localparam int unsigned LEAVES = 1 << LVLS;
  localparam int unsigned KEY_W  = tlbl_pkg::AGE_W + 1;
  localparam int unsigned CNT_W  = $clog2(LVLS + 1);

  logic                       valid_q [ENTRIES];
  logic [PAGE_W-1:0]          page_q  [ENTRIES];
  logic [FRAME_W-1:0]         frame_q [ENTRIES];
  logic [tlbl_pkg::AGE_W-1:0] age_q   [ENTRIES];

  logic [KEY_W-1:0] leaf_key [LEAVES];
  logic [KEY_W-1:0] key_q    [LVLS][LEAVES/2];
  logic [IDX_W-1:0] idx_q    [LVLS][LEAVES/2];
  logic [CNT_W-1:0] settle_q;

  // lookup, lowest matching index wins
  always_comb begin
    hit_o     = 1'b0;
    hit_idx_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (page_q[i] == look_page_i)) begin
        hit_o     = 1'b1;
        hit_idx_o = IDX_W'(i);
      end
    end
  end

  assign hit_frame_o = frame_q[hit_idx_o];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        age_q[i]   <= '0;
      end
    end else begin
      if (op_i.touch) begin
        age_q[op_idx_i] <= op_age_i;
      end
      if (op_i.fill) begin
        valid_q[op_idx_i] <= 1'b1;
        age_q[op_idx_i]   <= op_age_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.fill) begin
      page_q[op_idx_i]  <= op_page_i;
      frame_q[op_idx_i] <= op_frame_i;
    end
  end

  // invalid entries sort below any valid age, padding never wins
  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < ENTRIES) begin : g_real
      assign leaf_key[g] = valid_q[g] ? {1'b1, age_q[g]} : '0;
    end else begin : g_pad
      assign leaf_key[g] = '1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < LEAVES / 2; j++) begin
      if (leaf_key[2*j+1] < leaf_key[2*j]) begin
        key_q[0][j] <= leaf_key[2*j+1];
        idx_q[0][j] <= IDX_W'(2*j+1);
      end else begin
        key_q[0][j] <= leaf_key[2*j];
        idx_q[0][j] <= IDX_W'(2*j);
      end
    end
    for (int l = 1; l < LVLS; l++) begin
      for (int j = 0; j < (LEAVES >> (l + 1)); j++) begin
        if (key_q[l-1][2*j+1] < key_q[l-1][2*j]) begin
          key_q[l][j] <= key_q[l-1][2*j+1];
          idx_q[l][j] <= idx_q[l-1][2*j+1];
        end else begin
          key_q[l][j] <= key_q[l-1][2*j];
          idx_q[l][j] <= idx_q[l-1][2*j];
        end
      end
    end
  end

  assign victim_o = idx_q[LVLS-1][0];

  // tree output trails any entry change through the registered levels of the tree
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= '0;
    end else if (op_i.touch || op_i.fill) begin
      settle_q <= CNT_W'(LVLS);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - CNT_W'(1);
    end
  end

  assign settled_o = (settle_q == '0);

endmodule

[rtl/tlb_lru_page_translator_core.sv]
// tlb page translator top: one result strobe per transfer, registered after the LOOK and
// RESOLVE states; the next transfer is taken as the last one resolves; a miss that refills
// the tlb right after a tlb update waits in RESOLVE for the lru age tree to settle
// after reset busy_o stays high while the page table is cleared
// the receiver cannot stall; depends on tlbl_pkg, tlbl_tlb, tlbl_pt_mem
module tlb_lru_page_translator_core #(
  parameter int unsigned TLB_ENTRIES = tlbl_pkg::DEF_TLB_ENTRIES,
  parameter int unsigned PAGE_COUNT  = tlbl_pkg::DEF_PAGE_COUNT,
  parameter int unsigned FRAME_COUNT = tlbl_pkg::DEF_FRAME_COUNT,
  parameter int unsigned PAGE_BYTES  = tlbl_pkg::DEF_PAGE_BYTES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [tlbl_pkg::ADDR_W-1:0]      logical_address_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [tlbl_pkg::ADDR_W-1:0]      physical_address_o,
  output logic [1:0]                       status_o,
  output logic [tlbl_pkg::FRAME_OUT_W-1:0] frame_number_o,
  output logic [tlbl_pkg::TOTAL_W-1:0]     hit_total_o,
  output logic [tlbl_pkg::TOTAL_W-1:0]     fault_total_o
);

  localparam int unsigned PG_W    = $clog2(PAGE_COUNT);
  localparam int unsigned FRAME_W = $clog2(FRAME_COUNT);
  localparam int unsigned OFF_W   = $clog2(PAGE_BYTES);
  localparam int unsigned NF_W    = $clog2(FRAME_COUNT + 1);
  localparam int unsigned IDX_W   = $clog2(TLB_ENTRIES);
  localparam int unsigned PTE_W   = FRAME_W + 1;

  tlbl_pkg::fsm_e    state_q, state_d;
  tlbl_pkg::status_e status_c;
  tlbl_pkg::tlb_op_t tlb_op;

  logic              accept;
  logic [PG_W-1:0]   page_q;
  logic [OFF_W-1:0]  offset_q;
  logic [PG_W-1:0]   clr_q;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [FRAME_W-1:0] hit_frame_q;
  logic [NF_W-1:0]   next_free_q;
  logic [31:0]       access_q, hits_q, faults_q;
  logic [31:0]       addr_w, phys_w, frame_w;

  logic              look_hit;
  logic [IDX_W-1:0]  look_idx;
  logic [FRAME_W-1:0] look_frame;
  logic [IDX_W-1:0]  victim;
  logic              settled;

  logic              pt_rd_en, pt_wr_en;
  logic [PG_W-1:0]   pt_wr_addr;
  logic [PTE_W-1:0]  pt_rd_data, pt_wr_data;

  logic              pte_present, no_frame, need_fill, go, mapped;
  logic [FRAME_W-1:0] frame_c;

  logic              done_q;
  logic [tlbl_pkg::ADDR_W-1:0]      phys_q;
  logic [1:0]                       status_q;
  logic [tlbl_pkg::FRAME_OUT_W-1:0] frame_q;

  tlbl_tlb #(
    .ENTRIES (TLB_ENTRIES),
    .PAGE_W  (PG_W),
    .FRAME_W (FRAME_W)
  ) u_tlb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .look_page_i (page_q),
    .hit_o       (look_hit),
    .hit_idx_o   (look_idx),
    .hit_frame_o (look_frame),
    .op_i        (tlb_op),
    .op_idx_i    (hit_q ? hit_idx_q : victim),
    .op_page_i   (page_q),
    .op_frame_i  (frame_c),
    .op_age_i    (access_q),
    .victim_o    (victim),
    .settled_o   (settled)
  );

  tlbl_pt_mem #(
    .DEPTH (PAGE_COUNT),
    .WIDTH (PTE_W)
  ) u_pt_mem (
    .clk_i     (clk_i),
    .rd_en_i   (pt_rd_en),
    .rd_addr_i (page_q),
    .rd_data_o (pt_rd_data),
    .wr_en_i   (pt_wr_en),
    .wr_addr_i (pt_wr_addr),
    .wr_data_i (pt_wr_data)
  );

  assign addr_w      = 32'(logical_address_i) >> OFF_W;
  assign pte_present = pt_rd_data[FRAME_W];
  assign no_frame    = (next_free_q == NF_W'(FRAME_COUNT));

  always_comb begin
    status_c  = tlbl_pkg::ST_TLB_HIT;
    frame_c   = '0;
    need_fill = 1'b0;
    if (hit_q) begin
      frame_c = hit_frame_q;
    end else if (pte_present) begin
      status_c  = tlbl_pkg::ST_PT_HIT;
      frame_c   = pt_rd_data[FRAME_W-1:0];
      need_fill = 1'b1;
    end else if (no_frame) begin
      status_c = tlbl_pkg::ST_NO_FRAME;
    end else begin
      status_c  = tlbl_pkg::ST_FAULT;
      frame_c   = next_free_q[FRAME_W-1:0];
      need_fill = 1'b1;
    end
  end

  assign go     = !need_fill || settled;
  assign mapped = !hit_q && !pte_present && !no_frame;

  always_comb begin
    state_d      = state_q;
    busy_o       = 1'b1;
    pt_rd_en     = 1'b0;
    pt_wr_en     = 1'b0;
    pt_wr_addr   = page_q;
    pt_wr_data   = {1'b1, frame_c};
    tlb_op.touch = 1'b0;
    tlb_op.fill  = 1'b0;
    unique case (state_q)
      tlbl_pkg::FSM_CLEAR: begin
        pt_wr_en   = 1'b1;
        pt_wr_addr = clr_q;
        pt_wr_data = '0;
        if (clr_q == PG_W'(PAGE_COUNT - 1)) begin
          state_d = tlbl_pkg::FSM_IDLE;
        end
      end
      tlbl_pkg::FSM_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          state_d = tlbl_pkg::FSM_LOOK;
        end
      end
      tlbl_pkg::FSM_LOOK: begin
        pt_rd_en = 1'b1;
        state_d  = tlbl_pkg::FSM_RESOLVE;
      end
      tlbl_pkg::FSM_RESOLVE: begin
        if (go) begin
          busy_o       = 1'b0;
          tlb_op.touch = hit_q;
          tlb_op.fill  = need_fill;
          pt_wr_en     = mapped;
          state_d      = start_i ? tlbl_pkg::FSM_LOOK : tlbl_pkg::FSM_IDLE;
        end
      end
      default: state_d = tlbl_pkg::FSM_IDLE;
    endcase
  end

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlbl_pkg::FSM_CLEAR;
      clr_q       <= '0;
      next_free_q <= '0;
      access_q    <= '0;
      hits_q      <= '0;
      faults_q    <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (state_q == tlbl_pkg::FSM_CLEAR) begin
        clr_q <= clr_q + PG_W'(1);
      end
      if (state_q == tlbl_pkg::FSM_RESOLVE && go) begin
        done_q   <= 1'b1;
        access_q <= tlbl_pkg::sat_inc(access_q);
        if (hit_q) begin
          hits_q <= tlbl_pkg::sat_inc(hits_q);
        end
        if (!hit_q && !pte_present) begin
          faults_q <= tlbl_pkg::sat_inc(faults_q);
        end
        if (mapped) begin
          next_free_q <= next_free_q + NF_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q   <= addr_w[PG_W-1:0];
      offset_q <= logical_address_i[OFF_W-1:0];
    end
    if (state_q == tlbl_pkg::FSM_LOOK) begin
      hit_q       <= look_hit;
      hit_idx_q   <= look_idx;
      hit_frame_q <= look_frame;
    end
  end

  assign frame_w = 32'(frame_c);
  assign phys_w  = (frame_w << OFF_W) | 32'(offset_q);

  always_ff @(posedge clk_i) begin
    if (state_q == tlbl_pkg::FSM_RESOLVE && go) begin
      status_q <= status_c;
      if (status_c == tlbl_pkg::ST_NO_FRAME) begin
        phys_q  <= '0;
        frame_q <= '0;
      end else begin
        phys_q  <= phys_w[tlbl_pkg::ADDR_W-1:0];
        frame_q <= frame_w[tlbl_pkg::FRAME_OUT_W-1:0];
      end
    end
  end

  assign done_o             = done_q;
  assign physical_address_o = phys_q;
  assign status_o           = status_q;
  assign frame_number_o     = frame_q;
  assign hit_total_o        = hits_q;
  assign fault_total_o      = faults_q;

endmodule

[rtl/tlbl_checker.sv]
// port-level checks for the tlb page translator, bound to the top level
// depends on tlbl_pkg and tlb_lru_page_translator_core_defines.svh
`include "tlb_lru_page_translator_core_defines.svh"

module tlbl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [15:0] physical_address_o,
  input logic [1:0]  status_o,
  input logic [7:0]  frame_number_o,
  input logic [31:0] hit_total_o,
  input logic [31:0] fault_total_o
);

  logic res_no_frame, res_hit, res_fault, res_zero;

  assign res_no_frame = done_o && (status_o == tlbl_pkg::ST_NO_FRAME);
  assign res_hit      = done_o && (status_o == tlbl_pkg::ST_TLB_HIT);
  assign res_fault    = done_o && ((status_o == tlbl_pkg::ST_FAULT) ||
                                   (status_o == tlbl_pkg::ST_NO_FRAME));
  assign res_zero     = (physical_address_o == 16'd0) && (frame_number_o == 8'd0);

  `TLBL_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o, "no busy after transfer")
  `TLBL_ASSERT_IMP(a_done_after_busy, done_o, $past(busy_o, 2), "result without work")
  `TLBL_ASSERT_IMP(a_no_frame_zero, res_no_frame, res_zero, "no-frame result not zeroed")
  `TLBL_ASSERT_IMP(a_hit_counted, res_hit, hit_total_o != 32'd0, "tlb hit not counted")
  `TLBL_ASSERT_IMP(a_fault_counted, res_fault, fault_total_o != 32'd0, "fault not counted")

endmodule

bind tlb_lru_page_translator_core tlbl_checker u_tlbl_checker (.*);

[tb/sv/tlb_lru_page_translator_core_tb.sv]
// self-checking testbench for tlb_lru_page_translator_core: directed and random address streams
// a shadow tlb and page table predict every translation; depends on tlbl_pkg and the core
module tlb_lru_page_translator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TLB_N      = tlbl_pkg::DEF_TLB_ENTRIES;
  localparam int PAGE_N     = tlbl_pkg::DEF_PAGE_COUNT;
  localparam int FRAME_N    = tlbl_pkg::DEF_FRAME_COUNT;
  localparam int PAGE_SIZE  = tlbl_pkg::DEF_PAGE_BYTES;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [tlbl_pkg::ADDR_W-1:0]      phys;
    tlbl_pkg::status_e                status;
    logic [tlbl_pkg::FRAME_OUT_W-1:0] frame;
    logic [tlbl_pkg::TOTAL_W-1:0]     hits;
    logic [tlbl_pkg::TOTAL_W-1:0]     faults;
  } translation_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             start_i = 1'b0;
  logic [tlbl_pkg::ADDR_W-1:0]      logical_address_i = '0;
  logic                             busy_o;
  logic                             done_o;
  logic [tlbl_pkg::ADDR_W-1:0]      physical_address_o;
  logic [1:0]                       status_o;
  logic [tlbl_pkg::FRAME_OUT_W-1:0] frame_number_o;
  logic [tlbl_pkg::TOTAL_W-1:0]     hit_total_o;
  logic [tlbl_pkg::TOTAL_W-1:0]     fault_total_o;

  // shadow translation state
  bit           shadow_tlb_valid [TLB_N];
  logic [7:0]   shadow_tlb_page  [TLB_N];
  logic [7:0]   shadow_tlb_frame [TLB_N];
  logic [31:0]  shadow_tlb_age   [TLB_N];
  bit           shadow_present   [PAGE_N];
  logic [7:0]   shadow_page_frame[PAGE_N];
  int unsigned  shadow_next_frame;
  logic [31:0]  shadow_access_num = '0;
  logic [31:0]  shadow_hits = '0;
  logic [31:0]  shadow_faults = '0;

  translation_t pending_translations[$];
  int           mismatch_count;
  int           results_seen;
  int           status_tally[4];
  int           idle_cycles;
  bit           no_gap_run;

  tlb_lru_page_translator_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .logical_address_i  (logical_address_i),
    .busy_o             (busy_o),
    .done_o             (done_o),
    .physical_address_o (physical_address_o),
    .status_o           (status_o),
    .frame_number_o     (frame_number_o),
    .hit_total_o        (hit_total_o),
    .fault_total_o      (fault_total_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic translation_t predict_translation(
    input logic [tlbl_pkg::ADDR_W-1:0] addr);
    translation_t res;
    int unsigned  page;
    int unsigned  offset;
    int unsigned  frame;
    int           slot;
    int           victim;
    bit           found;
    bit           mapped;
    page   = (addr / PAGE_SIZE) % PAGE_N;
    offset = addr % PAGE_SIZE;
    frame  = 0;
    slot   = 0;
    found  = 1'b0;
    mapped = 1'b1;
    for (int i = 0; i < TLB_N; i++) begin
      if (!found && shadow_tlb_valid[i] && shadow_tlb_page[i] == page) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      frame = 32'(shadow_tlb_frame[slot]);
      shadow_tlb_age[slot] = shadow_access_num;
      if (shadow_hits != '1) shadow_hits++;
      res.status = tlbl_pkg::ST_TLB_HIT;
    end else begin
      if (shadow_present[page]) begin
        frame = 32'(shadow_page_frame[page]);
        res.status = tlbl_pkg::ST_PT_HIT;
      end else begin
        if (shadow_faults != '1) shadow_faults++;
        if (shadow_next_frame >= FRAME_N) begin
          res.status = tlbl_pkg::ST_NO_FRAME;
          mapped = 1'b0;
        end else begin
          frame = shadow_next_frame;
          shadow_next_frame++;
          shadow_page_frame[page] = 8'(frame);
          shadow_present[page] = 1'b1;
          res.status = tlbl_pkg::ST_FAULT;
        end
      end
      if (mapped) begin
        // first free slot, else oldest age with the lowest index on ties
        victim = -1;
        for (int i = 0; i < TLB_N; i++) begin
          if (victim < 0 && !shadow_tlb_valid[i]) victim = i;
        end
        if (victim < 0) begin
          victim = 0;
          for (int i = 1; i < TLB_N; i++) begin
            if (shadow_tlb_age[i] < shadow_tlb_age[victim]) victim = i;
          end
        end
        shadow_tlb_valid[victim] = 1'b1;
        shadow_tlb_page[victim]  = 8'(page);
        shadow_tlb_frame[victim] = 8'(frame);
        shadow_tlb_age[victim]   = shadow_access_num;
      end
    end
    res.phys   = mapped ? tlbl_pkg::ADDR_W'(frame * PAGE_SIZE + offset) : '0;
    res.frame  = mapped ? tlbl_pkg::FRAME_OUT_W'(frame) : '0;
    res.hits   = shadow_hits;
    res.faults = shadow_faults;
    if (shadow_access_num != '1) shadow_access_num++;
    status_tally[res.status]++;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // predict on every input transfer, check on every result strobe
  always @(posedge clk_i) begin
    translation_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        results_seen++;
        if (pending_translations.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(physical_address_o), 32'd0);
        end else begin
          want = pending_translations.pop_front();
          if (physical_address_o !== want.phys)
            report_mismatch("physical_address", 32'(physical_address_o), 32'(want.phys));
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (frame_number_o !== want.frame)
            report_mismatch("frame_number", 32'(frame_number_o), 32'(want.frame));
          if (hit_total_o !== want.hits)
            report_mismatch("hit_total", hit_total_o, want.hits);
          if (fault_total_o !== want.faults)
            report_mismatch("fault_total", fault_total_o, want.faults);
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0)
        pending_translations.push_back(predict_translation(logical_address_i));
    end
  end

  always @(posedge clk_i) begin
    if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_address(input logic [tlbl_pkg::ADDR_W-1:0] addr);
    int gap;
    if ($urandom_range(0, 39) == 0) no_gap_run = !no_gap_run;
    gap = no_gap_run ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    logical_address_i <= addr;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic test_directed_edges();
    send_address(16'h0000);
    send_address(16'h00FF);
    send_address(16'hFFFF);
    send_address(16'hFF00);
    send_address(16'h8000);
    send_address(16'h7FFF);
    for (int p = 1; p <= 16; p++) send_address({8'(p), 8'(p * 15)});
    // early pages were evicted, so these come back from the page table
    send_address(16'h0012);
    send_address(16'hFFA5);
    send_address(16'h805A);
  endtask

  task automatic test_tlb_locality();
    int         set_size;
    logic [7:0] work_set[32];
    for (int round = 0; round < 5; round++) begin
      set_size = $urandom_range(2, TLB_N);
      for (int k = 0; k < set_size; k++) work_set[k] = 8'($urandom);
      repeat (100) send_address({work_set[$urandom_range(0, set_size - 1)], 8'($urandom)});
    end
  endtask

  task automatic test_lru_thrash();
    int         set_size;
    int         pick;
    logic [7:0] work_set[32];
    for (int round = 0; round < 5; round++) begin
      set_size = $urandom_range(TLB_N + 1, 32);
      for (int k = 0; k < set_size; k++) work_set[k] = 8'($urandom);
      for (int k = 0; k < 100; k++) begin
        pick = ($urandom_range(0, 4) < 3) ? k % set_size : $urandom_range(0, set_size - 1);
        send_address({work_set[pick], 8'($urandom)});
      end
    end
  endtask

  task automatic test_random_addresses();
    repeat (500) send_address(tlbl_pkg::ADDR_W'($urandom_range(0, 65535)));
  endtask

  task automatic test_page_sweep();
    int order[PAGE_N];
    int j;
    int tmp;
    for (int i = 0; i < PAGE_N; i++) order[i] = i;
    for (int i = PAGE_N - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < PAGE_N; i++) send_address({8'(order[i]), 8'($urandom)});
  endtask

  task automatic test_after_full_map();
    logic [7:0] base;
    repeat (5) begin
      base = 8'($urandom);
      repeat (25) send_address({8'(base + $urandom_range(0, 7)), 8'($urandom)});
      repeat (25) send_address(tlbl_pkg::ADDR_W'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_tlb_locality();
    test_lru_thrash();
    test_random_addresses();
    test_page_sweep();
    test_after_full_map();
    start_i <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("checked %0d translations: %0d tlb hits, %0d table hits, %0d faults, %0d unmapped",
             results_seen, status_tally[tlbl_pkg::ST_TLB_HIT],
             status_tally[tlbl_pkg::ST_PT_HIT], status_tally[tlbl_pkg::ST_FAULT],
             status_tally[tlbl_pkg::ST_NO_FRAME]);
    $display("frames assigned %0d of %0d, mismatches %0d", shadow_next_frame, FRAME_N,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
